// ===== sv/pli_pkg.sv =====
`timescale 1ns / 1ps
package pli_pkg;

  localparam int PLI_CAPACITY = 32;

  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STS_BADPOS   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STS_FULL     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_t;

  // what a cell loads at the next edge
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_LEFT,
    SEL_RIGHT
  } cell_sel_t;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
  } req_t;

endpackage

// ===== sv/pli_cell.sv =====
`timescale 1ns / 1ps
module pli_cell
  import pli_pkg::*;
(
  input  logic                      clk,
  input  cell_sel_t                 sel,
  input  logic signed [VALUE_W-1:0] load_value,
  input  logic signed [VALUE_W-1:0] left_data,
  input  logic signed [VALUE_W-1:0] right_data,
  output logic signed [VALUE_W-1:0] data,
  output logic                      eq
);

  logic signed [VALUE_W-1:0] data_r;
  logic signed [VALUE_W-1:0] data_nxt;

  // pick the next entry: hold, take the request value, or shift from a neighbor
  always_comb begin
    case (sel)
      SEL_HOLD:  data_nxt = data_r;
      SEL_LOAD:  data_nxt = load_value;
      SEL_LEFT:  data_nxt = left_data;
      SEL_RIGHT: data_nxt = right_data;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign eq   = (data_r == load_value);

endmodule

// ===== sv/pli_ctrl.sv =====
`timescale 1ns / 1ps
module pli_ctrl
  import pli_pkg::*;
#(
  parameter int CAPACITY = PLI_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  req_t                      in_req,
  output logic                      in_ready,
  input  logic [CAPACITY-1:0]       cell_eq,
  output cell_sel_t                 cell_sel [CAPACITY],
  output logic signed [VALUE_W-1:0] req_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATUS_W-1:0]       out_status,
  output logic [COUNT_W-1:0]        out_count,
  output logic                      out_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t state_r, state_nxt;
  req_t   req_r, req_nxt;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CAPACITY-1:0] match_r, match_nxt;
  logic [CAPACITY-1:0] hit_low, at_or_above_hit;
  logic [CAPACITY-1:0] below_count;
  logic [CMP_W-1:0]    pos_ext, count_ext;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [COUNT_W-1:0]  ocount_r, ocount_nxt;
  logic                empty_r, empty_nxt;

  logic load_req, capture_match, apply_go;
  logic full, found, pos_bad;
  logic [STATUS_W-1:0] status_calc;
  logic [CNT_W-1:0]    count_calc;

  assign pos_ext   = CMP_W'(req_r.pos);
  assign count_ext = CMP_W'(count_r);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign pos_bad   = (pos_ext > count_ext);
  assign found     = |match_r;

  // isolate the lowest matching cell and mark it and every cell above
  assign hit_low         = match_r & (~match_r + CAPACITY'(1));
  assign at_or_above_hit = ~(hit_low - CAPACITY'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_APPLY;
      ST_APPLY: if (apply_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready      = 1'b0;
    load_req      = 1'b0;
    capture_match = 1'b0;
    apply_go      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        load_req = in_valid;
      end
      ST_CMP:   capture_match = 1'b1;
      ST_APPLY: apply_go = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // hold the request while it is worked on
  assign req_nxt   = load_req ? in_req : req_r;
  assign req_value = req_r.value;

  // flag live entries for the compare results and choose what each cell loads
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell_ctl
      assign below_count[g] = (CNT_W'(g) < count_r);

      always_comb begin
        cell_sel[g] = SEL_HOLD;
        if (apply_go) begin
          case (req_r.op)
            OP_APPEND: begin
              if (!full && CNT_W'(g) == count_r) cell_sel[g] = SEL_LOAD;
            end
            OP_INSERT: begin
              if (!pos_bad && !full) begin
                if (CMP_W'(g) == pos_ext) begin
                  cell_sel[g] = SEL_LOAD;
                end else if (CMP_W'(g) > pos_ext && CMP_W'(g) <= count_ext) begin
                  cell_sel[g] = SEL_LEFT;
                end
              end
            end
            OP_DELETE: begin
              if (found && at_or_above_hit[g] && (CNT_W'(g) + CNT_W'(1)) < count_r) begin
                cell_sel[g] = SEL_RIGHT;
              end
            end
            default: cell_sel[g] = SEL_HOLD;
          endcase
        end
      end
    end
  endgenerate

  assign match_nxt = capture_match ? (cell_eq & below_count) : match_r;

  // status and new count of the operation
  always_comb begin
    status_calc = STS_DONE;
    count_calc  = count_r;
    case (req_r.op)
      OP_APPEND: begin
        if (full) status_calc = STS_FULL;
        else count_calc = count_r + CNT_W'(1);
      end
      OP_INSERT: begin
        if (pos_bad) status_calc = STS_BADPOS;
        else if (full) status_calc = STS_FULL;
        else count_calc = count_r + CNT_W'(1);
      end
      OP_DELETE: begin
        if (!found) status_calc = STS_NOTFOUND;
        else count_calc = count_r - CNT_W'(1);
      end
      default: status_calc = STS_DONE;
    endcase
  end

  assign count_nxt = apply_go ? count_calc : count_r;

  // result register: load on apply, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    ocount_nxt    = ocount_r;
    empty_nxt     = empty_r;
    if (apply_go) begin
      out_valid_nxt = 1'b1;
      status_nxt    = status_calc;
      ocount_nxt    = COUNT_W'(count_calc);
      empty_nxt     = (count_calc == '0);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    match_r  <= match_nxt;
    status_r <= status_nxt;
    ocount_r <= ocount_nxt;
    empty_r  <= empty_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_count  = ocount_r;
  assign out_empty  = empty_r;

endmodule

// ===== sv/positional_list_insert_delete.sv =====
`timescale 1ns / 1ps
// Ordered list of signed 32-bit entries held in a row of cells, one entry
// per cell. Each request on the in_ stream asks for append, insert at a
// position, or delete of the first entry equal to a value; each request
// yields exactly one result on the out_ stream carrying status, entry
// count and an empty flag.
// Sequence: a request is taken in the idle state, the cells compare in the
// compare state, and the shift and result load happen in the apply state,
// after which the result shows on out_tvalid. A new request is taken only
// once the previous one has been applied, as set by the request register,
// the registered match vector and the apply step of the control sequencer.
// A result waits in the output register while out_tready is low; the next
// request is still accepted, and its apply step holds until the waiting
// result is taken.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; cell contents are not cleared and need no clearing pass, since
// only entries below the count are ever used.
module positional_list_insert_delete
  import pli_pkg::*;
#(
  parameter int CAPACITY = PLI_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], position[37:32], zero pad
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // count[5:0], zero pad
  output logic [2:0]  out_tuser   // status[1:0], empty_res[2]
);

  req_t                      in_req;
  logic signed [VALUE_W-1:0] req_value;
  logic signed [VALUE_W-1:0] ent [CAPACITY];
  logic [CAPACITY-1:0]       cell_eq;
  cell_sel_t                 cell_sel [CAPACITY];
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        count;
  logic                      empty_res;

  // unpack the request
  assign in_req.op    = in_tuser;
  assign in_req.value = in_tdata[31:0];
  assign in_req.pos   = in_tdata[37:32];

  pli_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_req     (in_req),
    .in_ready   (in_tready),
    .cell_eq    (cell_eq),
    .cell_sel   (cell_sel),
    .req_value  (req_value),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status),
    .out_count  (count),
    .out_empty  (empty_res)
  );

  // row of cells, each linked to its neighbors, the ends fed zero
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cells
      logic signed [VALUE_W-1:0] left_d, right_d;
      if (g == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = ent[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = ent[g+1];
      end

      pli_cell u_cell (
        .clk        (clk),
        .sel        (cell_sel[g]),
        .load_value (req_value),
        .left_data  (left_d),
        .right_data (right_d),
        .data       (ent[g]),
        .eq         (cell_eq[g])
      );
    end
  endgenerate

  // pack the result
  assign out_tdata = {2'b00, count};
  assign out_tuser = {empty_res, status};

endmodule

// ===== test/tb_positional_list_insert_delete.sv =====
`timescale 1ns / 1ps
module tb_positional_list_insert_delete;
  import pli_pkg::*;

  // the one operation code the block leaves unused
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1650;
  localparam int HOLD_CYCLES  = 80;
  localparam int MAX_PRINTS   = 50;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                empty;
  } list_result_t;

  // Tracks the list contents and the results still owed by the block
  class list_tracker;
    logic [VALUE_W-1:0] cells [PLI_CAPACITY];
    int unsigned        fill;
    list_result_t       pending_results [$];
    int                 errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Apply one operation to the tracked list and return its status
    function logic [STATUS_W-1:0] apply_list_op(logic [OP_W-1:0] op,
                                                 logic [VALUE_W-1:0] value,
                                                 logic [POS_W-1:0] pos);
      int i;
      int hit;
      hit = -1;
      case (op)
        OP_APPEND: begin
          if (fill >= PLI_CAPACITY) return STS_FULL;
          cells[fill] = value;
          fill++;
          return STS_DONE;
        end
        OP_INSERT: begin
          // range check ranks above the full check
          if (int'(pos) > int'(fill)) return STS_BADPOS;
          if (fill >= PLI_CAPACITY) return STS_FULL;
          for (i = int'(fill); i > int'(pos); i--) cells[i] = cells[i-1];
          cells[pos] = value;
          fill++;
          return STS_DONE;
        end
        OP_DELETE: begin
          // lowest matching position wins
          for (i = 0; i < int'(fill); i++) begin
            if (hit < 0 && cells[i] == value) hit = i;
          end
          if (hit < 0) return STS_NOTFOUND;
          for (i = hit; i + 1 < int'(fill); i++) cells[i] = cells[i+1];
          fill--;
          return STS_DONE;
        end
        default: return STS_DONE;
      endcase
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                               logic [POS_W-1:0] pos);
      list_result_t res;
      res.status = apply_list_op(op, value, pos);
      res.count  = COUNT_W'(fill);
      res.empty  = (fill == 0);
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count,
                      logic empty);
      list_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with none pending");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (count !== want.count)
          report_mismatch($sformatf("count %0d, want %0d", count, want.count));
        if (empty !== want.empty)
          report_mismatch($sformatf("empty %0b, want %0b", empty, want.empty));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;

  list_tracker list_sb;
  bit          hold_off_req;
  int          quiet_tx;
  int          quiet_rx;

  positional_list_insert_delete dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, and now and then a quiet stretch
  function automatic int pick_gap(inout int quiet_left);
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Offer one request and hold it until the block takes it
  task send_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                 logic [POS_W-1:0] pos);
    int gap;
    gap = pick_gap(quiet_tx);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, pos, value};
    do @(posedge clk); while (!in_tready);
    list_sb.note_request(op, value, pos);
  endtask

  // Value for append or insert: wide random, small with repeats, or a copy
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20 && list_sb.fill > 0)
      return list_sb.cells[$urandom_range(0, list_sb.fill - 1)];
    if (r < 60) return VALUE_W'($urandom_range(0, 15)) - 32'd8;
    return $urandom;
  endfunction

  // Value to delete: usually one that is in the list
  function automatic logic [VALUE_W-1:0] pick_victim();
    if (list_sb.fill > 0 && $urandom_range(0, 99) < 80)
      return list_sb.cells[$urandom_range(0, list_sb.fill - 1)];
    return pick_value();
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return POS_W'($urandom_range(0, list_sb.fill));
    if (r < 88) return POS_W'($urandom_range(list_sb.fill, PLI_CAPACITY));
    return POS_W'($urandom_range(0, 63));
  endfunction

  // Receiver: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    quiet_rx   = 0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap(quiet_rx);
      end
    end
  end

  // Check every result taken at a rising edge
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready)
        list_sb.check_result(out_tuser[1:0], out_tdata[5:0], out_tuser[2]);
    end
  end

  // Stimulus
  initial begin
    int n;
    int r;
    int waited;
    int probe_left;
    bit growing;
    logic [OP_W-1:0] op;

    list_sb      = new();
    hold_off_req = 1'b0;
    quiet_tx     = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_APPEND;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list corner cases, extremes, repeats, unused code
    send_item(OP_DELETE, 32'd5, 6'd0);
    send_item(OP_INSERT, 32'd1, 6'd1);
    send_item(OP_INSERT, 32'd2, 6'd63);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
    send_item(OP_INSERT, 32'h7FFF_FFFF, 6'd0);
    send_item(OP_APPEND, 32'h8000_0000, 6'd0);
    send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
    send_item(OP_APPEND, 32'd0, 6'd17);
    send_item(OP_INSERT, 32'd7, 6'd4);
    send_item(OP_INSERT, 32'd7, 6'd2);
    send_item(OP_INSERT, 32'd9, 6'd7);
    send_item(OP_INSERT, 32'd9, 6'd32);
    send_item(OP_DELETE, 32'd7, 6'd0);
    send_item(OP_DELETE, 32'd7, 6'd0);
    send_item(OP_DELETE, 32'd7, 6'd0);
    send_item(OP_UNUSED, 32'h1234_5678, 6'd1);
    send_item(OP_DELETE, 32'h8000_0000, 6'd0);
    send_item(OP_DELETE, 32'h7FFF_FFFF, 6'd0);
    send_item(OP_DELETE, 32'hFFFF_FFFF, 6'd0);
    send_item(OP_DELETE, 32'd0, 6'd0);
    send_item(OP_APPEND, 32'd42, 6'd0);
    send_item(OP_DELETE, 32'd42, 6'd0);

    // random: alternate filling to capacity and draining to empty
    growing    = 1'b1;
    probe_left = 4;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200) begin
        hold_off_req = 1'b1;
        quiet_tx     = 40;
      end
      if (growing && list_sb.fill == PLI_CAPACITY) begin
        if (probe_left == 0) begin
          growing    = 1'b0;
          probe_left = $urandom_range(1, 4);
        end else probe_left--;
      end else if (!growing && list_sb.fill == 0) begin
        if (probe_left == 0) begin
          growing    = 1'b1;
          probe_left = $urandom_range(1, 6);
        end else probe_left--;
      end
      r = $urandom_range(0, 99);
      if (r < 5) op = OP_UNUSED;
      else if (growing) op = (r < 50) ? OP_APPEND : (r < 90) ? OP_INSERT : OP_DELETE;
      else op = (r < 12) ? OP_APPEND : (r < 20) ? OP_INSERT : OP_DELETE;
      case (op)
        OP_DELETE: send_item(op, pick_victim(), POS_W'($urandom_range(0, 63)));
        OP_INSERT: send_item(op, pick_value(), pick_pos());
        default:   send_item(op, pick_value(), POS_W'($urandom_range(0, 63)));
      endcase
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // drain, then keep the clock running before the final check
    waited = 0;
    while (list_sb.pending_results.size() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (12) @(posedge clk);
    if (list_sb.pending_results.size() > 0)
      list_sb.report_mismatch($sformatf("%0d results never arrived",
                                        list_sb.pending_results.size()));
    if (list_sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
